### hdl/ssc_pkg.sv
`default_nettype none

package ssc_pkg;

  localparam int unsigned COORD_WIDTH_DEF = 32;

  // Normal path widths: normalized magnitudes are 31 bits, Q2.30 results 32 bits
  localparam int unsigned E_W       = 31;
  localparam int unsigned NRM_W     = 32;
  localparam int unsigned Q_W       = 64;
  localparam int unsigned L_W       = 32;
  localparam int unsigned SQ_STEPS  = 32;
  localparam int unsigned DIV_STEPS = 32;

  typedef struct packed {
    logic [E_W-1:0] e_x;
    logic [E_W-1:0] e_y;
    logic [E_W-1:0] e_z;
    logic [2:0]     neg;
    logic           hit;
    logic           zero;
  } ssc_carry_t;

  typedef struct packed {
    logic [Q_W-1:0] x;
    logic [Q_W-1:0] r;
  } ssc_sqrt_t;

  typedef struct packed {
    logic [L_W:0]   rem;
    logic [L_W-1:0] quo;
  } ssc_div_t;

  // One digit of the root: trial bit is 4^(31-j)
  function automatic ssc_sqrt_t sqrt_step(ssc_sqrt_t s, logic [4:0] j);
    logic [Q_W-1:0] bitv;
    logic [Q_W-1:0] t;
    ssc_sqrt_t      o;
    bitv = 64'd1 << (7'd62 - {1'b0, j, 1'b0});
    t    = s.r + bitv;
    if (s.x >= t) begin
      o.x = s.x - t;
      o.r = (s.r >> 1) + bitv;
    end else begin
      o.x = s.x;
      o.r = s.r >> 1;
    end
    return o;
  endfunction

  // One quotient bit of a restoring division; the dividend has no bits left below
  function automatic ssc_div_t div_step(ssc_div_t s, logic [L_W-1:0] den);
    logic [L_W:0] rem2;
    ssc_div_t     o;
    logic         qb;
    rem2 = {s.rem[L_W-1:0], 1'b0};
    if (rem2 >= {1'b0, den}) begin
      o.rem = rem2 - {1'b0, den};
      qb    = 1'b1;
    end else begin
      o.rem = rem2;
      qb    = 1'b0;
    end
    o.quo = {s.quo[L_W-2:0], qb};
    return o;
  endfunction

endpackage

`default_nettype wire

### hdl/sphere_sphere_contact.sv
`default_nettype none

// Sphere-sphere contact test. Each transaction carries two Q16.16 centres and
// two radii; the result reports hit (in tuser) and the unit normal from A to B
// in Q2.30 (zero when there is no hit or the centres coincide). The datapath is
// a fixed pipeline of 73 register stages: five for the difference, squares,
// compare and normalizing shift, 33 for the bit-per-stage integer square root,
// 33 for the bit-per-stage reciprocal, one multiply stage and the output
// register. A new pair is taken every cycle while the output is not stalled.
// A stall on the output freezes the whole pipeline.
module sphere_sphere_contact #(
  parameter int unsigned COORD_WIDTH = ssc_pkg::COORD_WIDTH_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     s_axis_tvalid,
  output      logic                     s_axis_tready,
  // centre_a_x, centre_a_y, centre_a_z, centre_b_x, centre_b_y, centre_b_z,
  // radius_a, radius_b, zero pad
  input  wire logic [8*COORD_WIDTH-1:0] s_axis_tdata,
  output      logic                     m_axis_tvalid,
  input  wire logic                     m_axis_tready,
  // normal_x, normal_y, normal_z
  output      logic [3*ssc_pkg::NRM_W-1:0] m_axis_tdata,
  // hit
  output      logic                     m_axis_tuser
);
  import ssc_pkg::*;

  localparam int unsigned W   = COORD_WIDTH;
  localparam int unsigned DW  = W + 1;
  localparam int unsigned H   = (DW + 1) / 2;
  localparam int unsigned HW  = DW - H;
  localparam int unsigned RH  = (W + 1) / 2;
  localparam int unsigned RHW = W - RH;
  localparam int unsigned SW  = 2 * DW + 2;
  localparam int unsigned PW  = $clog2(DW);
  localparam int unsigned NST = 5 + (SQ_STEPS + 1) + (DIV_STEPS + 1) + 2;

  logic           adv;
  logic [NST-1:0] vld_q;

  assign adv           = !vld_q[NST-1] || m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = vld_q[NST-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NST-2:0], s_axis_tvalid};
    end
  end

  // Stage 1: differences and magnitudes
  logic [DW-1:0] d_s0   [3];
  logic [DW-1:0] mag_s0 [3];
  logic [W-1:0]  rsum_s0;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d_s0[i] = {s_axis_tdata[(i+3)*W + W-1], s_axis_tdata[(i+3)*W +: W]}
              - {s_axis_tdata[i*W + W-1], s_axis_tdata[i*W +: W]};
      mag_s0[i] = d_s0[i][DW-1] ? (DW'(0) - d_s0[i]) : d_s0[i];
    end
    rsum_s0 = {1'b0, s_axis_tdata[6*W +: W-1]} + {1'b0, s_axis_tdata[7*W-1 +: W-1]};
  end

  logic [DW-1:0] mag1_q [3];
  logic [2:0]    neg1_q;
  logic [W-1:0]  rsum1_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        mag1_q[i] <= mag_s0[i];
        neg1_q[i] <= d_s0[i][DW-1];
      end
      rsum1_q <= rsum_s0;
    end
  end

  // Stage 2: partial products of the squares, largest magnitude
  logic [2*HW-1:0]  hh2_q [3];
  logic [HW+H-1:0]  hl2_q [3];
  logic [2*H-1:0]   ll2_q [3];
  logic [2*RHW-1:0] rhh2_q;
  logic [RHW+RH-1:0] rhl2_q;
  logic [2*RH-1:0]  rll2_q;
  logic [DW-1:0]    mag2_q [3];
  logic [DW-1:0]    m2_q;
  logic [2:0]       neg2_q;
  logic [DW-1:0]    m_s1;

  always_comb begin
    m_s1 = mag1_q[0];
    if (mag1_q[1] > m_s1) m_s1 = mag1_q[1];
    if (mag1_q[2] > m_s1) m_s1 = mag1_q[2];
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        hh2_q[i]  <= (2*HW)'(mag1_q[i][DW-1:H]) * (2*HW)'(mag1_q[i][DW-1:H]);
        hl2_q[i]  <= (HW+H)'(mag1_q[i][DW-1:H]) * (HW+H)'(mag1_q[i][H-1:0]);
        ll2_q[i]  <= (2*H)'(mag1_q[i][H-1:0]) * (2*H)'(mag1_q[i][H-1:0]);
        mag2_q[i] <= mag1_q[i];
      end
      rhh2_q <= (2*RHW)'(rsum1_q[W-1:RH]) * (2*RHW)'(rsum1_q[W-1:RH]);
      rhl2_q <= (RHW+RH)'(rsum1_q[W-1:RH]) * (RHW+RH)'(rsum1_q[RH-1:0]);
      rll2_q <= (2*RH)'(rsum1_q[RH-1:0]) * (2*RH)'(rsum1_q[RH-1:0]);
      m2_q   <= m_s1;
      neg2_q <= neg1_q;
    end
  end

  // Stage 3: assemble squares, find top bit of the largest magnitude
  logic [PW-1:0] p_s2;

  always_comb begin
    p_s2 = '0;
    for (int b = 0; b < DW; b++) begin
      if (m2_q[b]) p_s2 = PW'(b);
    end
  end

  logic [SW-1:0] sq3_q [3];
  logic [SW-1:0] r2_3_q;
  logic [PW-1:0] p3_q;
  logic [DW-1:0] mag3_q [3];
  logic [2:0]    neg3_q;
  logic          zero3_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        sq3_q[i] <= (SW'(hh2_q[i]) << (2*H)) + (SW'(hl2_q[i]) << (H+1)) + SW'(ll2_q[i]);
        mag3_q[i] <= mag2_q[i];
      end
      r2_3_q  <= (SW'(rhh2_q) << (2*RH)) + (SW'(rhl2_q) << (RH+1)) + SW'(rll2_q);
      p3_q    <= p_s2;
      neg3_q  <= neg2_q;
      zero3_q <= (m2_q == '0);
    end
  end

  // Stage 4: squared distance, normalizing shift to put the top bit at bit 30
  logic [E_W-1:0]  e_s3 [3];
  logic [6:0]      p7_s3;

  always_comb begin
    p7_s3 = 7'(p3_q);
    for (int i = 0; i < 3; i++) begin
      if (p7_s3 < 7'd30) begin
        e_s3[i] = E_W'((DW+E_W)'(mag3_q[i]) << (7'd30 - p7_s3));
      end else begin
        e_s3[i] = E_W'(mag3_q[i] >> (p7_s3 - 7'd30));
      end
    end
  end

  logic [SW-1:0]  s4_q;
  logic [SW-1:0]  r2_4_q;
  logic [E_W-1:0] e4_q [3];
  logic [2:0]     neg4_q;
  logic           zero4_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s4_q    <= sq3_q[0] + sq3_q[1] + sq3_q[2];
      r2_4_q  <= r2_3_q;
      for (int i = 0; i < 3; i++) e4_q[i] <= e_s3[i];
      neg4_q  <= neg3_q;
      zero4_q <= zero3_q;
    end
  end

  // Stage 5: compare, square the normalized components
  logic [2*E_W-1:0] ee5_q [3];
  ssc_carry_t       c5_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) ee5_q[i] <= (2*E_W)'(e4_q[i]) * (2*E_W)'(e4_q[i]);
      c5_q.e_x  <= e4_q[0];
      c5_q.e_y  <= e4_q[1];
      c5_q.e_z  <= e4_q[2];
      c5_q.neg  <= neg4_q;
      c5_q.hit  <= (s4_q <= r2_4_q);
      c5_q.zero <= zero4_q;
    end
  end

  // Square root: one result bit per stage
  ssc_sqrt_t  sq_q  [SQ_STEPS+1];
  ssc_carry_t csq_q [SQ_STEPS+1];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sq_q[0].x <= Q_W'(ee5_q[0]) + Q_W'(ee5_q[1]) + Q_W'(ee5_q[2]);
      sq_q[0].r <= '0;
      csq_q[0]  <= c5_q;
      for (int j = 0; j < SQ_STEPS; j++) begin
        sq_q[j+1]  <= sqrt_step(sq_q[j], 5'(j));
        csq_q[j+1] <= csq_q[j];
      end
    end
  end

  // Reciprocal 2^61 / L: one quotient bit per stage
  ssc_div_t       dv_q  [DIV_STEPS+1];
  logic [L_W-1:0] den_q [DIV_STEPS+1];
  ssc_carry_t     cdv_q [DIV_STEPS+1];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dv_q[0].rem <= (L_W+1)'(1) << 29;
      dv_q[0].quo <= '0;
      den_q[0]    <= sq_q[SQ_STEPS].r[L_W-1:0];
      cdv_q[0]    <= csq_q[SQ_STEPS];
      for (int j = 0; j < DIV_STEPS; j++) begin
        dv_q[j+1]  <= div_step(dv_q[j], den_q[j]);
        den_q[j+1] <= den_q[j];
        cdv_q[j+1] <= cdv_q[j];
      end
    end
  end

  // Scale by the reciprocal
  logic [E_W+L_W-1:0] pr_q [3];
  ssc_carry_t         cpr_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pr_q[0] <= (E_W+L_W)'(cdv_q[DIV_STEPS].e_x) * (E_W+L_W)'(dv_q[DIV_STEPS].quo);
      pr_q[1] <= (E_W+L_W)'(cdv_q[DIV_STEPS].e_y) * (E_W+L_W)'(dv_q[DIV_STEPS].quo);
      pr_q[2] <= (E_W+L_W)'(cdv_q[DIV_STEPS].e_z) * (E_W+L_W)'(dv_q[DIV_STEPS].quo);
      cpr_q   <= cdv_q[DIV_STEPS];
    end
  end

  // Output register: round, restore sign, drop normal on miss or coincident centres
  logic [NRM_W-1:0] n_d [3];
  logic [NRM_W-1:0] n_q [3];
  logic             hit_q;
  logic [Q_W-1:0]   rnd;

  always_comb begin
    rnd = '0;
    for (int i = 0; i < 3; i++) begin
      rnd    = Q_W'(pr_q[i]) + (Q_W'(1) << 30);
      n_d[i] = rnd[NRM_W+30:31];
      if (cpr_q.neg[i]) n_d[i] = NRM_W'(0) - n_d[i];
      if (!cpr_q.hit || cpr_q.zero) n_d[i] = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) n_q[i] <= n_d[i];
      hit_q <= cpr_q.hit;
    end
  end

  assign m_axis_tdata = {n_q[2], n_q[1], n_q[0]};
  assign m_axis_tuser = hit_q;

endmodule

`default_nettype wire

### bench/sphere_sphere_contact_chk.sv
`timescale 1ns / 1ps

module sphere_sphere_contact_chk (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_valid_i,
  input  logic         s_ready_i,
  input  logic [255:0] s_data_i,
  input  logic         m_valid_i,
  input  logic         m_ready_i,
  input  logic [95:0]  m_data_i,
  input  logic         m_hit_i,
  output int           fail_count_o,
  output int           pending_o
);

  typedef struct packed {
    logic        hit;
    logic [31:0] nz;
    logic [31:0] ny;
    logic [31:0] nx;
  } contact_t;

  contact_t contact_q[$];
  int       mismatches;

  assign fail_count_o = mismatches;
  assign pending_o    = contact_q.size();

  function automatic logic [63:0] root_floor(logic [63:0] x);
    logic [63:0] res;
    logic [63:0] bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x   = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic contact_t predict_contact(logic [255:0] item);
    logic signed [33:0] dv [3];
    logic [32:0]        mag [3];
    logic [63:0]        e [3];
    logic [127:0]       dist2;
    logic [127:0]       rad2;
    logic [31:0]        rsum;
    logic [32:0]        mx;
    logic [63:0]        q;
    logic [63:0]        len;
    logic [63:0]        recip;
    logic [63:0]        nv;
    int                 p;
    contact_t           r;
    r     = '0;
    dist2 = 0;
    for (int i = 0; i < 3; i++) begin
      dv[i]  = $signed(item[32*(i+3) +: 32]) - $signed(item[32*i +: 32]);
      mag[i] = dv[i] < 0 ? 33'(-dv[i]) : 33'(dv[i]);
      dist2  = dist2 + 128'(mag[i]) * 128'(mag[i]);
    end
    rsum = 32'(item[192 +: 31]) + 32'(item[223 +: 31]);
    rad2 = 128'(rsum) * 128'(rsum);
    if (dist2 > rad2) return r;
    r.hit = 1'b1;
    mx = mag[0];
    if (mag[1] > mx) mx = mag[1];
    if (mag[2] > mx) mx = mag[2];
    if (mx == 0) return r;
    p = 0;
    for (int b = 0; b < 33; b++) if (mx[b]) p = b;
    q = 0;
    for (int i = 0; i < 3; i++) begin
      e[i] = p < 30 ? 64'(mag[i]) << (30 - p) : 64'(mag[i]) >> (p - 30);
      q    = q + e[i] * e[i];
    end
    len = root_floor(q);
    if (len == 0) return r;
    recip = (64'd1 << 61) / len;
    for (int i = 0; i < 3; i++) begin
      nv = (e[i] * recip + (64'd1 << 30)) >> 31;
      if (dv[i] < 0) nv = -nv;
      if (i == 0) r.nx = nv[31:0];
      else if (i == 1) r.ny = nv[31:0];
      else r.nz = nv[31:0];
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    contact_t got;
    contact_t want;
    if (!rst_ni) begin
      mismatches = 0;
      contact_q.delete();
    end else begin
      if (s_valid_i && s_ready_i) contact_q.push_back(predict_contact(s_data_i));
      if (m_valid_i && m_ready_i) begin
        got = {m_hit_i, m_data_i[95:64], m_data_i[63:32], m_data_i[31:0]};
        if (contact_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", got);
        end else begin
          want = contact_q.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: hit %b/%b nx %h/%h ny %h/%h nz %h/%h (exp/act)",
                       want.hit, got.hit, want.nx, got.nx, want.ny, got.ny,
                       want.nz, got.nz);
          end
        end
      end
    end
  end

endmodule

### bench/sphere_sphere_contact_tb.sv
`timescale 1ns / 1ps

module sphere_sphere_contact_tb;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [255:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [95:0]  m_axis_tdata;
  logic         m_axis_tuser;
  int           fail_count;
  int           pending;
  int           cycles = 0;
  logic         hold_off = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  sphere_sphere_contact dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  sphere_sphere_contact_chk chk (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_valid_i(s_axis_tvalid), .s_ready_i(s_axis_tready), .s_data_i(s_axis_tdata),
    .m_valid_i(m_axis_tvalid), .m_ready_i(m_axis_tready), .m_data_i(m_axis_tdata),
    .m_hit_i(m_axis_tuser), .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Stall pattern: bursts of ready, random stalls, plus one long hold-off.
  always @(posedge clk_i) begin
    int ph;
    ph = cycles % 97;
    if (!rst_ni || hold_off) m_axis_tready <= 1'b0;
    else if (ph < 30) m_axis_tready <= 1'b1;
    else m_axis_tready <= ($urandom_range(0, 3) != 0);
  end

  initial begin
    repeat (300) @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (400) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(0, 2047) - 1024;
      3: return ($urandom_range(0, 65535) << 8) - (32'd1 << 23);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [255:0] make_pair(int mode);
    logic [255:0] v;
    logic [31:0]  c;
    v = '0;
    for (int i = 0; i < 6; i++) v[32*i +: 32] = rand_coord();
    if (mode == 1) begin
      // centre B near A: likely hit
      for (int i = 0; i < 3; i++) begin
        c = v[32*i +: 32] + (($urandom_range(0, 1) != 0) ? $urandom_range(0, 65535)
            : $urandom) % (32'd1 << $urandom_range(1, 28));
        v[32*(i+3) +: 32] = c;
      end
    end
    v[192 +: 31] = (mode == 1) ? 31'($urandom) >> $urandom_range(0, 8) : 31'($urandom);
    v[223 +: 31] = (mode == 1) ? 31'($urandom) >> $urandom_range(0, 8) : 31'($urandom);
    return v;
  endfunction

  task automatic send_pair(logic [255:0] v);
    s_axis_tdata  <= v;
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic idle_gap();
    s_axis_tvalid <= 1'b0;
    repeat ($urandom_range(1, 6)) @(posedge clk_i);
  endtask

  initial begin
    logic [255:0] v;
    int sent;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // coincident centres, touching spheres, extremes
    v = '0; send_pair(v);
    v = '0; v[192 +: 31] = 31'h7fff_ffff; v[223 +: 31] = 31'h7fff_ffff; send_pair(v);
    v = '0; v[96 +: 32] = 32'h0002_0000; v[192 +: 31] = 31'h1_0000;
    v[223 +: 31] = 31'h1_0000; send_pair(v);
    v[223 +: 31] = 31'h0_ffff; send_pair(v);
    v = '0; v[0 +: 32] = 32'h8000_0000; v[96 +: 32] = 32'h7fff_ffff;
    v[192 +: 31] = 31'h7fff_ffff; v[223 +: 31] = 31'h7fff_ffff; send_pair(v);
    v = '0; v[0 +: 96] = {3{32'h7fff_ffff}}; v[96 +: 96] = {3{32'h8000_0000}};
    v[192 +: 62] = '1; send_pair(v);
    v = '0; v[160 +: 32] = 32'hffff_ffff; v[192 +: 31] = 31'd1; send_pair(v);
    v = '0; v[64 +: 32] = 32'd1; v[96 +: 32] = 32'hffff_ffff; v[128 +: 32] = 32'd3;
    v[223 +: 31] = 31'd100; send_pair(v);
    for (int i = 0; i < 12; i++) send_pair({$urandom, $urandom, $urandom, $urandom,
                                           $urandom, $urandom, $urandom, $urandom});
    sent = 0;
    while (sent < 1550) begin
      repeat ($urandom_range(1, 40)) begin
        send_pair(make_pair($urandom_range(0, 2)));
        sent++;
      end
      if (sent > 700 && sent < 760) begin
        // drain everything before continuing
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(posedge clk_i);
      end
      if ($urandom_range(0, 2) != 0) idle_gap();
    end
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule

### sim.f
hdl/ssc_pkg.sv
hdl/sphere_sphere_contact.sv
bench/sphere_sphere_contact_chk.sv
bench/sphere_sphere_contact_tb.sv
